### src/blz_pkg.sv
// blz_pkg: shared types and constants for the backward lz decompressor
// used by the stream interfaces, the controller, the datapath and the top level
// no dependencies

package blz_pkg;

    // default number of history ring entries
    localparam int WINDOW_DEPTH_DEF = 8192;

    // token format
    localparam int FLAGS_PER_CTRL = 8;
    localparam int LEN_BIAS       = 3;
    localparam int DIST_BIAS      = 2;

    // one compressed byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } comp_item_t;

    // one decompressed result
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] out_position;
        logic        is_error;
        logic        run_last;
    } dec_item_t;

    // what the byte at the input does in the current decoder state
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_ONE,
        STEP_COPY
    } step_kind_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic copy_read;
        logic copy_emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        step_kind_t kind;
        logic       copy_last;
    } dp_stat_t;

endpackage

### src/blz_stream_if.sv
// blz_comp_if / blz_dec_if: valid-ready channels for compressed and decompressed items
// depends on blz_pkg

interface blz_comp_if;
    logic                valid;
    logic                ready;
    blz_pkg::comp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface blz_dec_if;
    logic               valid;
    logic               ready;
    blz_pkg::dec_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/backward_lz_decompressor_top.sv
// backward_lz_decompressor_top: backward lzss decoder, one compressed byte per transfer
// a literal or error result shows in the cycle after its transfer; a copy's first byte goes
// through the ring's registered read and then an emit step that waits for the sink; no new
// byte is taken while a copy runs, which walks one read and one emit step per copied byte
// reset: rst_n clears all control state at once, no clearing pass; output_size resets to 0
// depends on blz_pkg, blz_stream_if, blz_ctrl, blz_datapath

module backward_lz_decompressor_top #(
    parameter int WINDOW_DEPTH = blz_pkg::WINDOW_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    blz_comp_if.sink        comp,
    blz_dec_if.source       decomp,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_wdata
);

    // command and status between the sequencer and the datapath
    blz_pkg::dp_cmd_t   cmd;
    blz_pkg::dp_stat_t  stat;
    blz_pkg::dec_item_t out_item;
    logic               in_ready;
    logic               out_valid;

    // sequencer: takes a compressed byte when idle and the result register
    // is free or being drained this cycle; walks a back-reference as
    // alternating ring read and emit steps, the emit waiting for the sink
    blz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (comp.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (decomp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: decoder phase, flag shifter, write position and its ring
    // index, the history ring and the registered result; a write of
    // output_size re-arms the decoder for a new stream
    blz_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (comp.payload),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_item)
    );

    // channel hookup
    assign comp.ready     = in_ready;
    assign decomp.valid   = out_valid;
    assign decomp.payload = out_item;

endmodule

### src/blz_ctrl.sv
// blz_ctrl: sequencing state machine and output valid for the decompressor
// depends on blz_pkg

module blz_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  blz_pkg::dp_stat_t stat,
    output blz_pkg::dp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       out_load;

    // the result register can take a new result this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    cmd.accept = 1'b1;
                    if (stat.kind == blz_pkg::STEP_ONE)
                    begin
                        out_load = 1'b1;
                    end
                    else if (stat.kind == blz_pkg::STEP_COPY)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.copy_read = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.copy_emit = 1'b1;
                    out_load      = 1'b1;
                    state_next    = stat.copy_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a copy always starts with a ring read
    a_copy_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.kind == blz_pkg::STEP_COPY) |=> (state_reg == S_READ))
        else $error("copy did not start with a ring read");

    // every emitted copy byte was preceded by a read
    a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_emit |-> ($past(cmd.copy_read) || $past(state_reg) == S_EMIT))
        else $error("copy byte emitted without a ring read");

endmodule

### src/blz_datapath.sv
// blz_datapath: decoder state, history ring, copy counters and result register
// depends on blz_pkg

module blz_datapath #(
    parameter int WINDOW_DEPTH = blz_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  blz_pkg::comp_item_t in_item,
    input  blz_pkg::dp_cmd_t    cmd,
    output blz_pkg::dp_stat_t   stat,
    output blz_pkg::dec_item_t  out_item
);

    localparam int               IDX_W     = $clog2(WINDOW_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WINDOW_DEPTH - 1);

    // decode phases
    localparam logic [1:0] PH_CTRL = 2'd0;
    localparam logic [1:0] PH_ITEM = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    logic [31:0]      out_size_reg,  out_size_next;
    logic [31:0]      wp_reg,        wp_next;
    logic [IDX_W-1:0] wp_idx_reg,    wp_idx_next;
    logic [7:0]       flag_reg,      flag_next;
    logic [3:0]       flags_left_reg, flags_left_next;
    logic [7:0]       token_reg,     token_next;
    logic [1:0]       phase_reg,     phase_next;
    logic             halted_reg,    halted_next;
    logic [12:0]      dist_reg,      dist_next;
    logic [4:0]       cp_left_reg,   cp_left_next;
    logic             pend_reg,      pend_next;

    logic [7:0]       out_byte_reg;
    logic [31:0]      out_pos_reg;
    logic             out_err_reg;
    logic             out_last_reg;
    logic [7:0]       rd_data_reg;

    logic [7:0]       ring_mem [WINDOW_DEPTH];

    logic             eff_halt;
    logic             is_lit;
    logic             is_ref_err;
    logic [4:0]       tok_len;
    logic [12:0]      tok_dist;
    logic [32:0]      ref_end;
    logic [31:0]      wp_dec;
    logic [IDX_W-1:0] idx_dec;
    logic [3:0]       fl_dec;
    logic [IDX_W:0]   rd_sum;
    logic [IDX_W-1:0] rd_addr;
    logic             ring_we;
    logic [7:0]       ring_wdata;
    logic             out_load;
    logic             copy_last;

    assign eff_halt = halted_reg || (wp_reg == '0);
    assign wp_dec   = wp_reg - 32'd1;
    assign idx_dec  = (wp_idx_reg == '0) ? IDX_LAST : wp_idx_reg - 1'b1;
    assign fl_dec   = (flags_left_reg != 4'd0) ? flags_left_reg - 4'd1 : 4'd0;

    // back-reference fields from the high byte and the byte at the input
    assign tok_len    = {1'b0, token_reg[7:4]} + 5'(blz_pkg::LEN_BIAS);
    assign tok_dist   = {1'b0, token_reg[3:0], in_item.in_byte} + 13'(blz_pkg::DIST_BIAS);
    assign ref_end    = {1'b0, wp_reg} + {20'd0, tok_dist};
    assign is_ref_err = (wp_reg < {27'd0, tok_len}) || (ref_end >= {1'b0, out_size_reg});

    // ring read address: index of write position plus distance, wrapped once
    assign rd_sum  = {1'b0, wp_idx_reg} + (IDX_W + 1)'(dist_reg);
    assign rd_addr = (rd_sum >= DEPTH_EXT) ? IDX_W'(rd_sum - DEPTH_EXT) : rd_sum[IDX_W-1:0];

    assign copy_last = (cp_left_reg == 5'd1);

    always_comb
    begin
        stat.kind = blz_pkg::STEP_NONE;
        is_lit    = 1'b0;
        if (!eff_halt)
        begin
            unique case (phase_reg)
                PH_ITEM:
                begin
                    if (flag_reg[7])
                    begin
                        stat.kind = in_item.stream_end ? blz_pkg::STEP_ONE : blz_pkg::STEP_NONE;
                    end
                    else
                    begin
                        stat.kind = blz_pkg::STEP_ONE;
                        is_lit    = 1'b1;
                    end
                end
                PH_LOW:
                begin
                    stat.kind = is_ref_err ? blz_pkg::STEP_ONE : blz_pkg::STEP_COPY;
                end
                default:
                begin
                    stat.kind = blz_pkg::STEP_NONE;
                end
            endcase
        end
        stat.copy_last = copy_last;
    end

    always_comb
    begin
        out_size_next   = out_size_reg;
        wp_next         = wp_reg;
        wp_idx_next     = wp_idx_reg;
        flag_next       = flag_reg;
        flags_left_next = flags_left_reg;
        token_next      = token_reg;
        phase_next      = phase_reg;
        halted_next     = halted_reg;
        dist_next       = dist_reg;
        cp_left_next    = cp_left_reg;
        pend_next       = pend_reg;

        if (cmd.accept)
        begin
            if (eff_halt)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_CTRL:
                    begin
                        flag_next       = in_item.in_byte;
                        flags_left_next = 4'(blz_pkg::FLAGS_PER_CTRL);
                        phase_next      = PH_ITEM;
                    end
                    PH_ITEM:
                    begin
                        if (flag_reg[7])
                        begin
                            token_next = in_item.in_byte;
                            phase_next = PH_LOW;
                            if (in_item.stream_end)
                            begin
                                halted_next = 1'b1;
                            end
                        end
                        else
                        begin
                            wp_next         = wp_dec;
                            wp_idx_next     = idx_dec;
                            flag_next       = {flag_reg[6:0], 1'b0};
                            flags_left_next = fl_dec;
                            phase_next      = (fl_dec == 4'd0) ? PH_CTRL : PH_ITEM;
                        end
                    end
                    PH_LOW:
                    begin
                        if (is_ref_err)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            dist_next       = tok_dist;
                            cp_left_next    = tok_len;
                            pend_next       = in_item.stream_end;
                            flag_next       = {flag_reg[6:0], 1'b0};
                            flags_left_next = fl_dec;
                            phase_next      = (fl_dec == 4'd0) ? PH_CTRL : PH_ITEM;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_CTRL;
                    end
                endcase
            end
            // end of stream re-arms; a copy in flight loads the position at its end
            if (in_item.stream_end)
            begin
                flag_next       = '0;
                flags_left_next = '0;
                token_next      = '0;
                phase_next      = PH_CTRL;
                halted_next     = 1'b0;
                if (stat.kind != blz_pkg::STEP_COPY)
                begin
                    wp_next     = out_size_reg;
                    wp_idx_next = '0;
                end
            end
        end

        if (cmd.copy_emit)
        begin
            cp_left_next = cp_left_reg - 5'd1;
            if (copy_last && pend_reg)
            begin
                wp_next     = out_size_reg;
                wp_idx_next = '0;
                pend_next   = 1'b0;
            end
            else
            begin
                wp_next     = wp_dec;
                wp_idx_next = idx_dec;
            end
        end

        if (cfg_we)
        begin
            out_size_next   = cfg_wdata;
            wp_next         = cfg_wdata;
            wp_idx_next     = '0;
            flag_next       = '0;
            flags_left_next = '0;
            token_next      = '0;
            phase_next      = PH_CTRL;
            halted_next     = 1'b0;
            pend_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_size_reg   <= '0;
            wp_reg         <= '0;
            wp_idx_reg     <= '0;
            flag_reg       <= '0;
            flags_left_reg <= '0;
            token_reg      <= '0;
            phase_reg      <= PH_CTRL;
            halted_reg     <= 1'b0;
            dist_reg       <= '0;
            cp_left_reg    <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            out_size_reg   <= out_size_next;
            wp_reg         <= wp_next;
            wp_idx_reg     <= wp_idx_next;
            flag_reg       <= flag_next;
            flags_left_reg <= flags_left_next;
            token_reg      <= token_next;
            phase_reg      <= phase_next;
            halted_reg     <= halted_next;
            dist_reg       <= dist_next;
            cp_left_reg    <= cp_left_next;
            pend_reg       <= pend_next;
        end
    end

    // history ring, one write and one registered read port
    assign ring_we    = (cmd.accept && is_lit) || cmd.copy_emit;
    assign ring_wdata = cmd.copy_emit ? rd_data_reg : in_item.in_byte;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[idx_dec] <= ring_wdata;
        end
        if (cmd.copy_read)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // result register
    assign out_load = (cmd.accept && stat.kind == blz_pkg::STEP_ONE) || cmd.copy_emit;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (cmd.copy_emit)
            begin
                out_byte_reg <= rd_data_reg;
                out_pos_reg  <= wp_dec;
                out_err_reg  <= 1'b0;
                out_last_reg <= copy_last;
            end
            else
            begin
                out_byte_reg <= is_lit ? in_item.in_byte : 8'd0;
                out_pos_reg  <= is_lit ? wp_dec : wp_reg;
                out_err_reg  <= !is_lit;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign out_item.out_byte     = out_byte_reg;
    assign out_item.out_position = out_pos_reg;
    assign out_item.is_error     = out_err_reg;
    assign out_item.run_last     = out_last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wp_idx_reg} < DEPTH_EXT))
        else $error("ring write index beyond window");

    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_read |-> ({1'b0, rd_addr} < DEPTH_EXT))
        else $error("ring read address beyond window");

    a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.copy_read || cmd.copy_emit) |-> (cp_left_reg != 5'd0))
        else $error("copy step with no bytes left");

    a_emit_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.copy_emit && !(copy_last && pend_reg) && !cfg_we) |=> (wp_reg == $past(wp_dec)))
        else $error("copy byte did not move the write position down by one");

endmodule

### tb/tb_backward_lz_decompressor_top.sv
// tb_backward_lz_decompressor_top: self-checking testbench for the backward lzss decoder
// holds a small scoreboard class with its own decoder model, plus the driving tasks
// depends on blz_pkg, blz_stream_if and backward_lz_decompressor_top

class blz_scoreboard;
    typedef enum bit [1:0] {WANT_CTRL, WANT_ITEM, WANT_LOW} dec_phase_e;

    bit [7:0]           ring [blz_pkg::WINDOW_DEPTH_DEF];
    bit [31:0]          size_reg;
    bit [31:0]          wpos;
    bit [7:0]           flags;
    bit [3:0]           flags_left;
    bit [7:0]           hi_byte;
    dec_phase_e         phase;
    bit                 stopped;
    blz_pkg::dec_item_t due_q[$];
    int                 errors;

    function new();
        size_reg = '0;
        errors   = 0;
        restart();
    endfunction

    function void restart();
        wpos       = size_reg;
        flags      = '0;
        flags_left = '0;
        hi_byte    = '0;
        phase      = WANT_CTRL;
        stopped    = 1'b0;
    endfunction

    function void load_size(bit [31:0] v);
        size_reg = v;
        restart();
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    function void push_result(bit [7:0] b, bit [31:0] pos, bit err);
        blz_pkg::dec_item_t r;
        r.out_byte     = b;
        r.out_position = pos;
        r.is_error     = err;
        r.run_last     = 1'b0;
        due_q.push_back(r);
    endfunction

    function void store_byte(bit [7:0] b);
        wpos--;
        ring[wpos % blz_pkg::WINDOW_DEPTH_DEF] = b;
        push_result(b, wpos, 1'b0);
    endfunction

    function void advance_flag();
        flags = flags << 1;
        if (flags_left > 0)
            flags_left--;
        phase = (flags_left == 0) ? WANT_CTRL : WANT_ITEM;
    endfunction

    // one accepted compressed byte; returns 1 when the decoder was live for it
    function bit note_input(bit [7:0] b, bit last);
        int        first;
        bit [15:0] word;
        bit [4:0]  len;
        bit [12:0] tok_dist;
        bit        active;
        first = due_q.size();
        if (!stopped && wpos == 0)
            stopped = 1'b1;
        active = !stopped;
        if (!stopped)
        begin
            case (phase)
                WANT_CTRL:
                begin
                    flags      = b;
                    flags_left = 4'd8;
                    phase      = WANT_ITEM;
                end
                WANT_ITEM:
                begin
                    if (flags[7])
                    begin
                        hi_byte = b;
                        phase   = WANT_LOW;
                        if (last)
                        begin
                            push_result(8'h00, wpos, 1'b1);
                            stopped = 1'b1;
                        end
                    end
                    else
                    begin
                        store_byte(b);
                        advance_flag();
                    end
                end
                default:
                begin
                    word     = {hi_byte, b};
                    len      = 5'(word[15:12] + blz_pkg::LEN_BIAS);
                    tok_dist = 13'(word[11:0] + blz_pkg::DIST_BIAS);
                    if (wpos < len || ({1'b0, wpos} + tok_dist) >= {1'b0, size_reg})
                    begin
                        push_result(8'h00, wpos, 1'b1);
                        stopped = 1'b1;
                    end
                    else
                    begin
                        for (int j = 0; j < len; j++)
                            store_byte(ring[(wpos + tok_dist) % blz_pkg::WINDOW_DEPTH_DEF]);
                        advance_flag();
                    end
                end
            endcase
            if (!stopped && wpos == 0)
                stopped = 1'b1;
        end
        if (due_q.size() > first)
            due_q[due_q.size() - 1].run_last = 1'b1;
        if (last)
            restart();
        return active;
    endfunction

    function void check_result(blz_pkg::dec_item_t got);
        blz_pkg::dec_item_t want;
        if (due_q.size() == 0)
        begin
            errors++;
            $display("%0t: result with nothing expected: byte %02h pos %08h err %0b last %0b",
                     $time, got.out_byte, got.out_position, got.is_error, got.run_last);
            return;
        end
        want = due_q.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     want.out_byte, got.out_byte);
        end
        if (got.out_position !== want.out_position)
        begin
            errors++;
            $display("%0t: out_position expected %08h actual %08h", $time,
                     want.out_position, got.out_position);
        end
        if (got.is_error !== want.is_error)
        begin
            errors++;
            $display("%0t: is_error expected %0b actual %0b (pos %08h)", $time,
                     want.is_error, got.is_error, want.out_position);
        end
        if (got.run_last !== want.run_last)
        begin
            errors++;
            $display("%0t: run_last expected %0b actual %0b (pos %08h)", $time,
                     want.run_last, got.run_last, want.out_position);
        end
    endfunction
endclass

module tb_backward_lz_decompressor_top;

    // cycles to let pass once nothing is expected
    localparam int     SETTLE_CYCLES = 48;
    localparam int     RANDOM_ITEMS  = 450;
    localparam longint RUN_LIMIT     = 100_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    blz_comp_if comp_ch ();
    blz_dec_if  dec_ch ();

    blz_scoreboard sb;
    bit            gaps_on;
    bit [31:0]     out_size_now;
    int            active_items;

    backward_lz_decompressor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .comp      (comp_ch),
        .decomp    (dec_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle length for either side: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output sizes: mostly small, plus ring-wrap crossings, random values and the top of the range
    function automatic bit [31:0] pick_size(int idx);
        if (idx == 0)
            return 32'hFFFF_FFFF;
        case ($urandom_range(0, 9))
            0:             return $urandom_range(0, 2);
            1, 2, 3, 4, 5: return $urandom_range(3, 300);
            6:             return blz_pkg::WINDOW_DEPTH_DEF * $urandom_range(1, 8)
                                  + $urandom_range(1, 150);
            7:             return 32'hFFFF_FFFF - $urandom_range(0, 50);
            8:             return $urandom;
            default:       return $urandom_range(3000, 6000);
        endcase
    endfunction

    // one compressed byte: optional idle lead-in, then hold valid until the transfer
    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        blz_pkg::comp_item_t item;
        int                  gap;
        gap             = pick_gap();
        item.in_byte    = b;
        item.stream_end = last;
        if (gap > 0)
        begin
            comp_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        comp_ch.valid   <= 1'b1;
        comp_ch.payload <= item;
        @(posedge clk);
        while (!comp_ch.ready)
            @(posedge clk);
        // transfer happened at this edge
        if (sb.note_input(b, last))
            active_items++;
        @(negedge clk);
    endtask

    // register write only with the decoder drained and quiet
    task automatic set_size(input logic [31:0] v);
        comp_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.load_size(v);
        out_size_now = v;
    endtask

    // builds a stream that decodes cleanly unless a noise token breaks it,
    // optionally cuts it anywhere, then sends it with stream_end on the final byte
    task automatic send_stream(input int unsigned groups, input int unsigned noise_pct);
        bit [7:0]        seq[$];
        bit [7:0]        ctrl;
        bit [15:0]       word;
        longint unsigned produced;
        longint unsigned room;
        int              ci;
        int              len;
        int              ref_dist;
        int              cut;
        bit              wrecked;
        produced = 0;
        room     = out_size_now;
        wrecked  = 1'b0;
        for (int g = 0; g < groups; g++)
        begin
            ctrl = 8'($urandom_range(0, 255));
            seq.push_back(ctrl);
            ci = seq.size() - 1;
            for (int k = 7; k >= 0; k--)
            begin
                if (ctrl[k] && !wrecked && $urandom_range(1, 100) <= noise_pct)
                begin
                    // random token, usually out of range or too long
                    seq.push_back(8'($urandom_range(0, 255)));
                    seq.push_back(8'($urandom_range(0, 255)));
                    wrecked = 1'b1;
                end
                else if (ctrl[k] && wrecked)
                begin
                    seq.push_back(8'($urandom_range(0, 255)));
                    seq.push_back(8'($urandom_range(0, 255)));
                end
                else if (ctrl[k] && produced >= 3 && room >= 3)
                begin
                    len      = $urandom_range(3, (room < 18) ? int'(room) : 18);
                    ref_dist = $urandom_range(2, (produced > 4098) ? 4097 : int'(produced - 1));
                    word     = 16'(((len - blz_pkg::LEN_BIAS) << 12)
                                   | (ref_dist - blz_pkg::DIST_BIAS));
                    seq.push_back(word[15:8]);
                    seq.push_back(word[7:0]);
                    produced += len;
                    room     -= len;
                end
                else
                begin
                    // a reference is not possible yet: turn the flag into a literal
                    ctrl[k] = 1'b0;
                    seq.push_back(8'($urandom_range(0, 255)));
                    if (!wrecked && room > 0)
                    begin
                        produced++;
                        room--;
                    end
                end
            end
            seq[ci] = ctrl;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, seq.size());
            while (seq.size() > cut)
                void'(seq.pop_back());
        end
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    // sink side: ready bursts broken by random stalls
    initial
    begin : sink_ready_gen
        int span;
        int gap;
        dec_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            dec_ch.ready <= 1'b1;
            span = $urandom_range(1, 20);
            repeat (span) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                dec_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    // every result transfer goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && dec_ch.valid && dec_ch.ready)
            sb.check_result(dec_ch.payload);
    end

    initial
    begin : run_limit
        #RUN_LIMIT;
        $display("backward_lz_decompressor_top test failed");
        $finish;
    end

    initial
    begin : stimulus
        int phase_idx;
        int n_streams;
        sb              = new();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        comp_ch.valid   = 1'b0;
        comp_ch.payload = '0;
        gaps_on         = 1'b1;
        out_size_now    = '0;
        active_items    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty output: the decoder ignores the whole stream
        set_size(32'h0000_0000);
        send_byte(8'h99, 1'b1);

        // literals at both byte extremes, shortest and longest copies,
        // then the stream ends on a token high byte
        set_size(32'd40);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h12, 1'b1);

        // reference past the end of the output, then a byte while halted
        send_byte(8'h80, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h11, 1'b1);

        // copy longer than the room left below the write position
        set_size(32'd6);
        send_byte(8'h10, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h00, 1'b1);

        // output runs out, later bytes are dropped without results
        set_size(32'd2);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE7, 1'b0);
        send_byte(8'h18, 1'b0);
        send_byte(8'h44, 1'b1);

        // random part: several output sizes, several streams per size;
        // some phases run with no idling on either side
        active_items = 0;
        phase_idx    = 0;
        while (active_items < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            set_size(pick_size(phase_idx));
            n_streams = $urandom_range(1, 4);
            for (int s = 0; s < n_streams; s++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_stream(0, 0);
                else
                    send_stream($urandom_range(1, 4), 8);
                if ($urandom_range(0, 9) == 0)
                begin
                    // broken sequence: raw random bytes
                    repeat ($urandom_range(1, 11))
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
            end
            phase_idx++;
        end

        // drain, then give any stray result time to show up
        comp_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("backward_lz_decompressor_top test passed");
        else
            $display("backward_lz_decompressor_top test failed");
        $finish;
    end

endmodule

### files.f
src/blz_pkg.sv
src/blz_stream_if.sv
src/blz_ctrl.sv
src/blz_datapath.sv
src/backward_lz_decompressor_top.sv
tb/tb_backward_lz_decompressor_top.sv
